// ----- design/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the linked list engine checkers
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge while reset is released
`define LLMS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// checked on every edge, reset included
`define LLMS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- design/llms_pkg.sv -----
// ---------------------------------------------------------------------------
// llms_pkg
// types, constants and helpers of the linked list move and swap engine
// ---------------------------------------------------------------------------
`default_nettype none

package llms_pkg;

  localparam int unsigned ENTRIES = 256;
  localparam int unsigned ADDR_W  = $clog2(ENTRIES);

  typedef logic [7:0]        idx_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [2:0] {
    MODE_LOAD   = 3'd0,
    MODE_AFTER  = 3'd1,
    MODE_BEFORE = 3'd2,
    MODE_SWAP   = 3'd3,
    MODE_READ   = 3'd4
  } mode_e;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_ZERO = 1'b1;

  typedef struct packed {
    logic [2:0] mode;
    idx_t       first_index;
    idx_t       second_index;
    idx_t       load_next;
    idx_t       load_prev;
  } in_item_t;

  typedef struct packed {
    idx_t first_next;
    idx_t first_prev;
    logic status;
  } out_item_t;

  // entry zero and indexes past the table are not real entries
  function automatic logic usable(idx_t i);
    return (i != '0) && (32'(i) < ENTRIES);
  endfunction

  function automatic addr_t to_addr(idx_t i);
    logic [ADDR_W+7:0] wide;
    wide = {{ADDR_W{1'b0}}, i};
    return wide[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- design/llms_in_if.sv -----
// ---------------------------------------------------------------------------
// llms_in_if
// request channel: valid/ready handshake with one operation item
// ---------------------------------------------------------------------------
`default_nettype none

interface llms_in_if;
  import llms_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- design/llms_out_if.sv -----
// ---------------------------------------------------------------------------
// llms_out_if
// result channel: valid/ready handshake with the links of entry A
// ---------------------------------------------------------------------------
`default_nettype none

interface llms_out_if;
  import llms_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- design/llms_ram.sv -----
// ---------------------------------------------------------------------------
// llms_ram
// single port ram, read-first, registered read data
// ---------------------------------------------------------------------------
`default_nettype none

module llms_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 256,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

`default_nettype wire

// ----- design/linked_list_move_swap_engine.sv -----
// ---------------------------------------------------------------------------
// linked_list_move_swap_engine
// doubly linked sequences in a successor ram and a predecessor ram:
// load, read, move after, move before and swap of entries
// ---------------------------------------------------------------------------
//  channel | dir | handshake   | payload
//  in_i    | in  | valid/ready | mode, first_index, second_index, load_next, load_prev
//  out_o   | out | valid/ready | first_next, first_prev, status
//
//  one item at a time; the read-modify-write walk over the two single port
//  link rams: load writes both links, a move unlinks and relinks entry A,
//  a swap is done as one or two moves, and a refused or same-entry move
//  or swap only reads; the result waits for a held result to be taken.
//  after reset a clearing pass zeroes all ENTRIES (256) words of both rams,
//  during which in_i.ready stays low.
//  the result sits in an output register, so a new item is taken while it waits.
// ---------------------------------------------------------------------------
`default_nettype none

module linked_list_move_swap_engine (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  llms_in_if.sink    in_i,
  llms_out_if.source out_o
);
  import llms_pkg::*;

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_LOAD   = 4'd2;
  localparam logic [3:0] S_MSTART = 4'd3;
  localparam logic [3:0] S_UNL    = 4'd4;
  localparam logic [3:0] S_ISO    = 4'd5;
  localparam logic [3:0] S_RDA    = 4'd6;
  localparam logic [3:0] S_LNK1   = 4'd7;
  localparam logic [3:0] S_LNK2   = 4'd8;
  localparam logic [3:0] S_SWA    = 4'd9;
  localparam logic [3:0] S_SWB    = 4'd10;
  localparam logic [3:0] S_SWD    = 4'd11;
  localparam logic [3:0] S_FRD    = 4'd12;
  localparam logic [3:0] S_FCAP   = 4'd13;

  logic [3:0] state_q, state_d;
  addr_t      clr_q, clr_d;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_data_q, out_data_d;
  in_item_t   item_q, item_d;
  logic       status_q, status_d;
  idx_t       mv_x_q, mv_x_d;
  idx_t       mv_a_q, mv_a_d;
  logic       mv_after_q, mv_after_d;
  logic       sec_q, sec_d;
  idx_t       pa_q, pa_d;
  idx_t       na_q, na_d;
  idx_t       t_q, t_d;
  logic       rd_ok_q;

  // ram side
  logic  clearing;
  logic  nx_req, pv_req;
  idx_t  nx_idx, pv_idx;
  idx_t  nx_wdata, pv_wdata;
  logic  nx_we, pv_we;
  addr_t nx_addr, pv_addr;
  idx_t  nx_rdata, pv_rdata;
  idx_t  nxt, pvt;
  logic  mv_done;

  llms_ram #(.WIDTH(8), .DEPTH(ENTRIES)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nx_we),
    .addr_i  (nx_addr),
    .wdata_i (nx_wdata),
    .rdata_o (nx_rdata)
  );

  llms_ram #(.WIDTH(8), .DEPTH(ENTRIES)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (pv_we),
    .addr_i  (pv_addr),
    .wdata_i (pv_wdata),
    .rdata_o (pv_rdata)
  );

  assign clearing = (state_q == S_CLR);
  assign nx_we    = clearing | (nx_req & usable(nx_idx));
  assign pv_we    = clearing | (pv_req & usable(pv_idx));
  assign nx_addr  = clearing ? clr_q : to_addr(nx_idx);
  assign pv_addr  = clearing ? clr_q : to_addr(pv_idx);

  // links read from entry zero or past the table read as none
  assign nxt = rd_ok_q ? nx_rdata : '0;
  assign pvt = rd_ok_q ? pv_rdata : '0;

  assign in_i.ready = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q & ~out_o.ready;
    out_data_d  = out_data_q;
    item_d      = item_q;
    status_d    = status_q;
    mv_x_d      = mv_x_q;
    mv_a_d      = mv_a_q;
    mv_after_d  = mv_after_q;
    sec_d       = sec_q;
    pa_d        = pa_q;
    na_d        = na_q;
    t_d         = t_q;
    nx_req      = 1'b0;
    pv_req      = 1'b0;
    nx_idx      = item_q.first_index;
    pv_idx      = item_q.first_index;
    nx_wdata    = '0;
    pv_wdata    = '0;
    mv_done     = 1'b0;

    case (state_q)
      S_CLR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == addr_t'(ENTRIES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_i.valid) begin
          item_d     = in_i.data;
          status_d   = STATUS_DONE;
          mv_x_d     = in_i.data.first_index;
          mv_a_d     = in_i.data.second_index;
          mv_after_d = (in_i.data.mode == MODE_AFTER);
          sec_d      = 1'b0;
          case (in_i.data.mode)
            MODE_LOAD: begin
              state_d = S_LOAD;
            end
            MODE_AFTER, MODE_BEFORE, MODE_SWAP: begin
              if (!usable(in_i.data.first_index) || !usable(in_i.data.second_index)) begin
                status_d = STATUS_ZERO;
                state_d  = S_FRD;
              end else if (in_i.data.first_index == in_i.data.second_index) begin
                state_d = S_FRD;
              end else if (in_i.data.mode == MODE_SWAP) begin
                state_d = S_SWA;
              end else begin
                state_d = S_MSTART;
              end
            end
            default: begin
              state_d = S_FRD;
            end
          endcase
        end
      end
      S_LOAD: begin
        nx_req   = 1'b1;
        pv_req   = 1'b1;
        nx_wdata = item_q.load_next;
        pv_wdata = item_q.load_prev;
        if (!usable(item_q.first_index)) begin
          status_d = STATUS_ZERO;
        end
        state_d = S_FRD;
      end
      S_MSTART: begin
        nx_idx = mv_x_q;
        pv_idx = mv_x_q;
        if (mv_x_q == mv_a_q) begin
          mv_done = 1'b1;
        end else begin
          state_d = S_UNL;
        end
      end
      S_UNL: begin
        // join the old neighbours of x
        pv_req   = 1'b1;
        pv_idx   = nxt;
        pv_wdata = pvt;
        nx_req   = 1'b1;
        nx_idx   = pvt;
        nx_wdata = nxt;
        state_d  = usable(mv_a_q) ? S_RDA : S_ISO;
      end
      S_ISO: begin
        nx_req  = 1'b1;
        pv_req  = 1'b1;
        nx_idx  = mv_x_q;
        pv_idx  = mv_x_q;
        mv_done = 1'b1;
      end
      S_RDA: begin
        nx_idx  = mv_a_q;
        pv_idx  = mv_a_q;
        state_d = S_LNK1;
      end
      S_LNK1: begin
        nx_req = 1'b1;
        pv_req = 1'b1;
        if (mv_after_q) begin
          t_d      = nxt;
          pv_idx   = nxt;
          pv_wdata = mv_x_q;
          nx_idx   = mv_a_q;
          nx_wdata = mv_x_q;
        end else begin
          t_d      = pvt;
          nx_idx   = pvt;
          nx_wdata = mv_x_q;
          pv_idx   = mv_a_q;
          pv_wdata = mv_x_q;
        end
        state_d = S_LNK2;
      end
      S_LNK2: begin
        nx_req   = 1'b1;
        pv_req   = 1'b1;
        nx_idx   = mv_x_q;
        pv_idx   = mv_x_q;
        nx_wdata = mv_after_q ? t_q : mv_a_q;
        pv_wdata = mv_after_q ? mv_a_q : t_q;
        mv_done  = 1'b1;
      end
      S_SWA: begin
        state_d = S_SWB;
      end
      S_SWB: begin
        na_d    = nxt;
        pa_d    = pvt;
        nx_idx  = item_q.second_index;
        pv_idx  = item_q.second_index;
        state_d = S_SWD;
      end
      S_SWD: begin
        mv_after_d = 1'b1;
        state_d    = S_MSTART;
        if (na_q == item_q.second_index) begin
          mv_x_d = item_q.first_index;
          mv_a_d = item_q.second_index;
          sec_d  = 1'b0;
        end else if (nxt == item_q.first_index) begin
          mv_x_d = item_q.second_index;
          mv_a_d = item_q.first_index;
          sec_d  = 1'b0;
        end else begin
          mv_x_d = item_q.first_index;
          mv_a_d = item_q.second_index;
          sec_d  = 1'b1;
        end
      end
      S_FRD: begin
        // only read once the output slot is free by the next edge
        if (!out_valid_q || out_o.ready) begin
          state_d = S_FCAP;
        end
      end
      S_FCAP: begin
        out_data_d  = '{first_next: nxt, first_prev: pvt, status: status_q};
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // end of one move: start the second half of a swap or finish
    if (mv_done) begin
      if (sec_q) begin
        sec_d      = 1'b0;
        mv_x_d     = item_q.second_index;
        mv_a_d     = (pa_q != '0) ? pa_q : na_q;
        mv_after_d = (pa_q != '0);
        state_d    = S_MSTART;
      end else begin
        state_d = S_FRD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    item_q     <= item_d;
    status_q   <= status_d;
    mv_x_q     <= mv_x_d;
    mv_a_q     <= mv_a_d;
    mv_after_q <= mv_after_d;
    sec_q      <= sec_d;
    pa_q       <= pa_d;
    na_q       <= na_d;
    t_q        <= t_d;
    rd_ok_q    <= usable(nx_idx);
  end

endmodule

`default_nettype wire

// ----- design/llms_checker.sv -----
// ---------------------------------------------------------------------------
// llms_checker
// port level checks of the linked list engine, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module llms_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_ready_i,
  input wire logic          out_valid_i,
  input wire logic          out_ready_i,
  input wire llms_pkg::idx_t out_first_next_i,
  input wire llms_pkg::idx_t out_first_prev_i,
  input wire logic          out_status_i
);

  // a held result stays offered
  `LLMS_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped while stalled")

  // a held result keeps its payload
  `LLMS_ASSERT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i |=> $stable(out_first_next_i) && $stable(out_first_prev_i) && $stable(out_status_i), "result changed while stalled")

  // one item at a time: the engine stays busy after each transfer in
  `LLMS_ASSERT(a_busy_after_in, clk_i, rst_ni, in_valid_i && in_ready_i |=> !in_ready_i ##1 !in_ready_i, "item taken while busy")

  // a new result appears together with the return to idle
  `LLMS_ASSERT(a_result_idle, clk_i, rst_ni, $rose(out_valid_i) |-> in_ready_i, "result without return to idle")

  // no item taken while in reset
  `LLMS_ASSERT_ALWAYS(a_reset_busy, clk_i, !rst_ni |-> !in_ready_i, "ready during reset")

endmodule

bind linked_list_move_swap_engine llms_checker u_llms_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_first_next_i (out_o.data.first_next),
  .out_first_prev_i (out_o.data.first_prev),
  .out_status_i     (out_o.data.status)
);

`default_nettype wire
